[hw/rtl/rmx_pkg.sv]
// Shared types and constants for the RAM machine execute unit.
// Holds the opcode, addressing mode, status and sequencer state encodings.
// No dependencies.
package rmx_pkg;

    localparam int REG_COUNT_DEF  = 128;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the stream fields.
    localparam int OP_W     = 4;
    localparam int MODE_W   = 2;
    localparam int OPND_W   = 8;
    localparam int TARGET_W = 10;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_READ  = 4'd6,
        OP_WRITE = 4'd7,
        OP_JUMP  = 4'd8,
        OP_JZERO = 4'd9,
        OP_JGTZ  = 4'd10,
        OP_HALT  = 4'd11
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DIRECT   = 2'd0,
        MODE_IMM      = 2'd1,
        MODE_INDIRECT = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_HALTED    = 3'd1,
        ST_BAD_MODE  = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_BAD_WRITE = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FETCH1,
        S_FETCH2,
        S_EXEC,
        S_MUL,
        S_DNEGA,
        S_DNEGB,
        S_DIV,
        S_DFIX,
        S_DONE
    } state_t;

endpackage

[hw/rtl/rmx_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ram_machine_execute_unit_top.sv]
// Execute unit of an accumulator random-access machine.
// Depends on rmx_pkg and rmx_ram.
//
// Usage:
// Each transfer on the slave stream (s_*) carries one decoded instruction;
// each instruction gives exactly one transfer on the master stream (m_*)
// with the accumulator, output tape value, tape and branch flags and status.
// The block works on one instruction at a time and s_tready is high only
// while the sequencer is idle. Halt, jumps, immediate write and errors found
// at decode go straight from decode to the result; other immediate ops pass
// through execute. A direct operand is fetched with one registered RAM read,
// an indirect one with two (pointer, then word). Multiply and divide use one
// shared adder stepping a shift-add multiply or a restoring divide, one bit a
// cycle; divide adds steps that take operand magnitudes and fix the quotient
// sign. s_tready rises in the cycle the result appears.
// The result sits in an output register, so the next instruction is taken
// while it waits; a stalled receiver holds the block only when a second
// result is ready before the first has been taken.
// After reset the register file is swept to zero, one word a cycle;
// s_tready stays low until the sweep has finished.
module ram_machine_execute_unit_top #(
    parameter int REG_COUNT  = rmx_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rmx_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op[3:0], mode[5:4], operand[13:6], jump_target[23:14],
    // tape_has_item[24], tape_value[56:25], zero[63:57]
    input  logic [rmx_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // acc_value[31:0], out_valid[32], out_value[64:33], tape_taken[65],
    // branch_taken[66], branch_target[76:67], status[79:77]
    output logic [rmx_pkg::M_DATA_W-1:0] m_tdata
);

    import rmx_pkg::*;

    localparam int D      = DATA_WIDTH;
    localparam int IDX_W  = $clog2(REG_COUNT);
    localparam int CMP_W  = ((D > 11) ? D : 11) + 1;
    localparam int CNT_W  = $clog2(D);

    // A register index is bad when negative or not below REG_COUNT.
    function automatic logic idx_bad(input logic [D-1:0] v);
        idx_bad = v[D-1] || (CMP_W'(v) >= CMP_W'(REG_COUNT));
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [D-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        to_idx = ext[IDX_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [D-1:0]          acc_reg, acc_next;
    logic                  m_valid_reg, m_valid_next;

    // Instruction fields held for the duration of the work.
    op_t                   op_reg, op_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [D-1:0]          opnd_reg, opnd_next;
    logic [TARGET_W-1:0]   target_reg, target_next;
    logic                  has_reg, has_next;
    logic [D-1:0]          tval_reg, tval_next;

    // Working registers of the shared unit.
    logic [D-1:0]          val_reg, val_next;
    logic [D-1:0]          work_reg, work_next;
    logic [D-1:0]          shf_reg, shf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  negb_reg, negb_next;

    // Result under construction.
    status_t               st_reg, st_next;
    logic                  ov_reg, ov_next;
    logic [D-1:0]          outv_reg, outv_next;
    logic                  taken_reg, taken_next;
    logic                  br_reg, br_next;

    // Output register.
    logic [WORD_W-1:0]     r_acc_reg, r_acc_next;
    logic                  r_ov_reg, r_ov_next;
    logic [WORD_W-1:0]     r_outv_reg, r_outv_next;
    logic                  r_taken_reg, r_taken_next;
    logic                  r_br_reg, r_br_next;
    logic [TARGET_W-1:0]   r_target_reg, r_target_next;
    status_t               r_st_reg, r_st_next;

    // Shared adder: add_a + (add_b ^ inv) + inv, with carry out on top.
    logic [D-1:0]          add_a, add_b;
    logic                  add_inv;
    logic [D:0]            add_sum;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [D-1:0]          ram_wdata, ram_rdata;

    logic [63:0]           opnd_x, tval_x, acc_x, outv_x;
    logic [D-1:0]          r_shift;

    rmx_ram #(
        .WIDTH (D),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {D{add_inv}}} + (D+1)'(add_inv);

    assign opnd_x  = 64'(signed'(s_tdata[13:6]));
    assign tval_x  = 64'(signed'(s_tdata[56:25]));
    assign acc_x   = 64'(signed'(acc_reg));
    assign outv_x  = 64'(signed'(outv_reg));
    assign r_shift = {work_reg[D-2:0], shf_reg[D-1]};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {r_st_reg, r_target_reg, r_br_reg, r_taken_reg,
                       r_outv_reg, r_ov_reg, r_acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        mode_reg     <= mode_next;
        opnd_reg     <= opnd_next;
        target_reg   <= target_next;
        has_reg      <= has_next;
        tval_reg     <= tval_next;
        val_reg      <= val_next;
        work_reg     <= work_next;
        shf_reg      <= shf_next;
        cnt_reg      <= cnt_next;
        negb_reg     <= negb_next;
        st_reg       <= st_next;
        ov_reg       <= ov_next;
        outv_reg     <= outv_next;
        taken_reg    <= taken_next;
        br_reg       <= br_next;
        r_acc_reg    <= r_acc_next;
        r_ov_reg     <= r_ov_next;
        r_outv_reg   <= r_outv_next;
        r_taken_reg  <= r_taken_next;
        r_br_reg     <= r_br_next;
        r_target_reg <= r_target_next;
        r_st_reg     <= r_st_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        mode_next     = mode_reg;
        opnd_next     = opnd_reg;
        target_next   = target_reg;
        has_next      = has_reg;
        tval_next     = tval_reg;
        val_next      = val_reg;
        work_next     = work_reg;
        shf_next      = shf_reg;
        cnt_next      = cnt_reg;
        negb_next     = negb_reg;
        st_next       = st_reg;
        ov_next       = ov_reg;
        outv_next     = outv_reg;
        taken_next    = taken_reg;
        br_next       = br_reg;
        r_acc_next    = r_acc_reg;
        r_ov_next     = r_ov_reg;
        r_outv_next   = r_outv_reg;
        r_taken_next  = r_taken_reg;
        r_br_next     = r_br_reg;
        r_target_next = r_target_reg;
        r_st_next     = r_st_reg;

        add_a     = acc_reg;
        add_b     = val_reg;
        add_inv   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = to_idx(opnd_reg);
        ram_wdata = acc_reg;
        ram_raddr = to_idx(opnd_reg);

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(REG_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = op_t'(s_tdata[3:0]);
                    mode_next   = s_tdata[5:4];
                    opnd_next   = opnd_x[D-1:0];
                    target_next = s_tdata[23:14];
                    has_next    = s_tdata[24];
                    tval_next   = tval_x[D-1:0];
                    st_next     = ST_OK;
                    ov_next     = 1'b0;
                    outv_next   = '0;
                    taken_next  = 1'b0;
                    br_next     = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (mode_reg == MODE_IMM)
                        begin
                            val_next   = opnd_reg;
                            state_next = S_EXEC;
                        end
                        else if (mode_reg != MODE_DIRECT && mode_reg != MODE_INDIRECT)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (idx_bad(opnd_reg))
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            state_next = S_FETCH1;
                        end
                    end

                    OP_STORE:
                    begin
                        if (mode_reg != MODE_DIRECT && mode_reg != MODE_INDIRECT)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (idx_bad(opnd_reg))
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else if (mode_reg == MODE_DIRECT)
                        begin
                            ram_we = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FETCH1;
                        end
                    end

                    OP_READ:
                    begin
                        // An empty tape makes read a no-op in any defined mode.
                        if (mode_reg != MODE_DIRECT && mode_reg != MODE_INDIRECT
                            && mode_reg != MODE_IMM)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (!has_reg)
                        begin
                            st_next = ST_OK;
                        end
                        else if (mode_reg != MODE_DIRECT)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (idx_bad(opnd_reg))
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = tval_reg;
                            taken_next = 1'b1;
                        end
                    end

                    OP_WRITE:
                    begin
                        if (mode_reg != MODE_DIRECT && mode_reg != MODE_INDIRECT
                            && mode_reg != MODE_IMM)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (opnd_reg[D-1] || opnd_reg == '0)
                        begin
                            st_next = ST_BAD_WRITE;
                        end
                        else if (mode_reg == MODE_IMM)
                        begin
                            ov_next   = 1'b1;
                            outv_next = opnd_reg;
                        end
                        else if (idx_bad(opnd_reg))
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            state_next = S_FETCH1;
                        end
                    end

                    OP_JUMP, OP_JZERO, OP_JGTZ:
                    begin
                        if (mode_reg != MODE_DIRECT)
                        begin
                            st_next = ST_BAD_MODE;
                        end
                        else if (op_reg == OP_JUMP)
                        begin
                            br_next = 1'b1;
                        end
                        else if (op_reg == OP_JZERO)
                        begin
                            br_next = (acc_reg == '0);
                        end
                        else
                        begin
                            br_next = (acc_reg != '0) && !acc_reg[D-1];
                        end
                    end

                    default:
                    begin
                        // Halt and the unused opcodes.
                        st_next = ST_HALTED;
                    end
                endcase
            end

            S_FETCH1:
            begin
                // ram_rdata holds the word at the operand index.
                if (mode_reg == MODE_DIRECT)
                begin
                    val_next   = ram_rdata;
                    state_next = S_EXEC;
                end
                else if (idx_bad(ram_rdata))
                begin
                    st_next    = ST_BAD_INDEX;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_STORE)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = to_idx(ram_rdata);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = to_idx(ram_rdata);
                    state_next = S_FETCH2;
                end
            end

            S_FETCH2:
            begin
                val_next   = ram_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        acc_next = val_reg;
                    end

                    OP_ADD:
                    begin
                        acc_next = add_sum[D-1:0];
                    end

                    OP_SUB:
                    begin
                        add_inv  = 1'b1;
                        acc_next = add_sum[D-1:0];
                    end

                    OP_MUL:
                    begin
                        work_next  = '0;
                        shf_next   = acc_reg;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end

                    OP_DIV:
                    begin
                        if (val_reg == '0)
                        begin
                            st_next = ST_DIV_ZERO;
                        end
                        else
                        begin
                            shf_next   = acc_reg;
                            negb_next  = val_reg[D-1];
                            state_next = S_DNEGA;
                        end
                    end

                    default:
                    begin
                        // Write: the fetched word goes to the output tape.
                        ov_next   = 1'b1;
                        outv_next = val_reg;
                    end
                endcase
            end

            S_MUL:
            begin
                // Shift-add: multiplier in shf_reg, multiplicand in val_reg.
                add_a     = work_reg;
                add_b     = shf_reg[0] ? val_reg : '0;
                work_next = add_sum[D-1:0];
                shf_next  = shf_reg >> 1;
                val_next  = val_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(D - 1))
                begin
                    acc_next   = add_sum[D-1:0];
                    state_next = S_DONE;
                end
            end

            S_DNEGA:
            begin
                add_a   = '0;
                add_b   = shf_reg;
                add_inv = 1'b1;
                if (acc_reg[D-1])
                begin
                    shf_next = add_sum[D-1:0];
                end
                state_next = S_DNEGB;
            end

            S_DNEGB:
            begin
                add_a   = '0;
                add_b   = val_reg;
                add_inv = 1'b1;
                if (negb_reg)
                begin
                    val_next = add_sum[D-1:0];
                end
                work_next  = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // Restoring step: the remainder stays below the divisor
                // magnitude, so the shifted remainder fits in D bits.
                add_a   = r_shift;
                add_b   = val_reg;
                add_inv = 1'b1;
                if (add_sum[D])
                begin
                    work_next = add_sum[D-1:0];
                    shf_next  = {shf_reg[D-2:0], 1'b1};
                end
                else
                begin
                    work_next = r_shift;
                    shf_next  = {shf_reg[D-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(D - 1))
                begin
                    state_next = S_DFIX;
                end
            end

            S_DFIX:
            begin
                add_a   = '0;
                add_b   = shf_reg;
                add_inv = 1'b1;
                if (acc_reg[D-1] != negb_reg)
                begin
                    acc_next = add_sum[D-1:0];
                end
                else
                begin
                    acc_next = shf_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    r_acc_next    = acc_x[WORD_W-1:0];
                    r_ov_next     = ov_reg;
                    r_outv_next   = ov_reg ? outv_x[WORD_W-1:0] : '0;
                    r_taken_next  = taken_reg;
                    r_br_next     = br_reg;
                    r_target_next = br_reg ? target_reg : '0;
                    r_st_next     = st_reg;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[tb/ram_machine_execute_unit_top_tb.sv]
// Self-checking testbench for the RAM machine execute unit top level.
// Drives decoded instructions on the slave stream and checks each master-stream
// result against a local model of the accumulator and register file. Uses rmx_pkg.
module ram_machine_execute_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmx_pkg::*;

    localparam int unsigned NUM_REGS    = REG_COUNT_DEF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          TAIL_CYCLES = 60;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;
    localparam logic [OP_W-1:0]   OP_BEYOND  = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [MODE_W-1:0]   mode;
        logic [OPND_W-1:0]   operand;
        logic [TARGET_W-1:0] jump_target;
        logic                tape_has_item;
        logic [WORD_W-1:0]   tape_value;
    } instr_t;

    typedef struct packed {
        logic [WORD_W-1:0]   acc_value;
        logic                out_valid;
        logic [WORD_W-1:0]   out_value;
        logic                tape_taken;
        logic                branch_taken;
        logic [TARGET_W-1:0] branch_target;
        logic [STATUS_W-1:0] status;
    } exec_result_t;

    typedef struct {
        instr_t       ins;
        bit           fixed_exp;
        exec_result_t expd;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Local copy of the machine state.
    logic [WORD_W-1:0] acc_model;
    logic [WORD_W-1:0] reg_model [NUM_REGS];

    exec_result_t pending_results [$];
    stim_row_t    stim_table [$];
    exec_result_t want_res;
    exec_result_t got_res;

    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len      = 0;
    int hold_id       = 0;

    ram_machine_execute_unit_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [STATUS_W-1:0] index_status(input logic [WORD_W-1:0] v,
                                                         output logic [WORD_W-1:0] idx);
        idx = v;
        if (v[WORD_W-1] || v >= NUM_REGS)
            return ST_BAD_INDEX;
        return ST_OK;
    endfunction

    // Effective register address for direct or indirect addressing.
    function automatic logic [STATUS_W-1:0] locate(input logic [MODE_W-1:0] mode,
                                                   input logic [WORD_W-1:0] opnd,
                                                   output logic [WORD_W-1:0] addr);
        logic [WORD_W-1:0]   ptr;
        logic [STATUS_W-1:0] st;
        addr = '0;
        st = index_status(opnd, ptr);
        if (st != ST_OK)
            return st;
        if (mode == MODE_DIRECT)
        begin
            addr = ptr;
            return ST_OK;
        end
        return index_status(reg_model[ptr], addr);
    endfunction

    function automatic logic [STATUS_W-1:0] operand_value(input logic [MODE_W-1:0] mode,
                                                          input logic [WORD_W-1:0] opnd,
                                                          output logic [WORD_W-1:0] val);
        logic [WORD_W-1:0]   addr;
        logic [STATUS_W-1:0] st;
        val = '0;
        if (mode == MODE_IMM)
        begin
            val = opnd;
            return ST_OK;
        end
        st = locate(mode, opnd, addr);
        if (st != ST_OK)
            return st;
        val = reg_model[addr];
        return ST_OK;
    endfunction

    // Division on magnitudes, truncating toward zero; the most negative value
    // over minus one wraps back to itself.
    function automatic logic [WORD_W-1:0] quotient(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] ma;
        logic [WORD_W-1:0] mb;
        logic [WORD_W-1:0] q;
        ma = a[WORD_W-1] ? -a : a;
        mb = b[WORD_W-1] ? -b : b;
        q = ma / mb;
        if (a[WORD_W-1] != b[WORD_W-1])
            q = -q;
        return q;
    endfunction

    // Executes one instruction on the local state and returns its result.
    function automatic exec_result_t execute_instr(input instr_t ins);
        exec_result_t        r;
        logic [WORD_W-1:0]   opnd;
        logic [WORD_W-1:0]   val;
        logic [WORD_W-1:0]   addr;
        logic [STATUS_W-1:0] st;
        r = '0;
        st = ST_OK;
        val = '0;
        addr = '0;
        opnd = {{(WORD_W-OPND_W){ins.operand[OPND_W-1]}}, ins.operand};
        if (ins.op >= OP_HALT)
            st = ST_HALTED;
        else if (ins.mode == MODE_BAD)
            st = ST_BAD_MODE;
        else
        begin
            case (ins.op)
                OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    st = operand_value(ins.mode, opnd, val);
                    if (st == ST_OK)
                    begin
                        case (ins.op)
                            OP_LOAD: acc_model = val;
                            OP_ADD:  acc_model = acc_model + val;
                            OP_SUB:  acc_model = acc_model - val;
                            OP_MUL:  acc_model = acc_model * val;
                            default:
                            begin
                                if (val == '0)
                                    st = ST_DIV_ZERO;
                                else
                                    acc_model = quotient(acc_model, val);
                            end
                        endcase
                    end
                end
                OP_STORE:
                begin
                    if (ins.mode == MODE_IMM)
                        st = ST_BAD_MODE;
                    else
                    begin
                        st = locate(ins.mode, opnd, addr);
                        if (st == ST_OK)
                            reg_model[addr] = acc_model;
                    end
                end
                OP_READ:
                begin
                    // An empty tape turns the read into a no-op before the mode matters.
                    if (ins.tape_has_item)
                    begin
                        if (ins.mode != MODE_DIRECT)
                            st = ST_BAD_MODE;
                        else
                        begin
                            st = locate(MODE_DIRECT, opnd, addr);
                            if (st == ST_OK)
                            begin
                                reg_model[addr] = ins.tape_value;
                                r.tape_taken = 1'b1;
                            end
                        end
                    end
                end
                OP_WRITE:
                begin
                    if (opnd[WORD_W-1] || opnd == '0)
                        st = ST_BAD_WRITE;
                    else
                    begin
                        st = operand_value(ins.mode, opnd, val);
                        if (st == ST_OK)
                        begin
                            r.out_valid = 1'b1;
                            r.out_value = val;
                        end
                    end
                end
                default:
                begin
                    if (ins.mode != MODE_DIRECT)
                        st = ST_BAD_MODE;
                    else if (ins.op == OP_JUMP)
                        r.branch_taken = 1'b1;
                    else if (ins.op == OP_JZERO)
                        r.branch_taken = (acc_model == '0);
                    else
                        r.branch_taken = (acc_model != '0) && !acc_model[WORD_W-1];
                end
            endcase
        end
        if (r.branch_taken)
            r.branch_target = ins.jump_target;
        r.acc_value = acc_model;
        r.status = st;
        return r;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_instr(input instr_t ins);
        return {7'd0, ins.tape_value, ins.tape_has_item, ins.jump_target,
                ins.operand, ins.mode, ins.op};
    endfunction

    function automatic exec_result_t unpack_result(input logic [M_DATA_W-1:0] d);
        exec_result_t r;
        r.acc_value     = d[31:0];
        r.out_valid     = d[32];
        r.out_value     = d[64:33];
        r.tape_taken    = d[65];
        r.branch_taken  = d[66];
        r.branch_target = d[76:67];
        r.status        = d[79:77];
        return r;
    endfunction

    // Mostly well-formed instructions on a small pool of registers, so that
    // stored values come back as operands and as pointers; a few are noise.
    function automatic instr_t random_instr();
        instr_t      ins;
        int unsigned pick;
        ins = '0;
        ins.jump_target   = TARGET_W'($urandom_range(1023));
        ins.tape_has_item = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 35)
            ins.tape_value = $urandom_range(15);
        else if (pick < 50)
            ins.tape_value = $urandom_range(140, 100);
        else
            ins.tape_value = $urandom;
        if ($urandom_range(99) < 8)
        begin
            ins.op      = OP_W'($urandom_range(15));
            ins.mode    = MODE_W'($urandom_range(3));
            ins.operand = OPND_W'($urandom_range(255));
            return ins;
        end
        pick = $urandom_range(99);
        if (pick < 14)      ins.op = OP_LOAD;
        else if (pick < 26) ins.op = OP_STORE;
        else if (pick < 34) ins.op = OP_ADD;
        else if (pick < 41) ins.op = OP_SUB;
        else if (pick < 47) ins.op = OP_MUL;
        else if (pick < 54) ins.op = OP_DIV;
        else if (pick < 67) ins.op = OP_READ;
        else if (pick < 78) ins.op = OP_WRITE;
        else if (pick < 82) ins.op = OP_JUMP;
        else if (pick < 89) ins.op = OP_JZERO;
        else if (pick < 96) ins.op = OP_JGTZ;
        else                ins.op = OP_HALT;
        pick = $urandom_range(99);
        case (ins.op)
            OP_STORE:
                ins.mode = (pick < 60) ? MODE_DIRECT : MODE_INDIRECT;
            OP_READ, OP_JUMP, OP_JZERO, OP_JGTZ:
                ins.mode = (pick < 90) ? MODE_DIRECT : MODE_W'($urandom_range(2, 1));
            OP_HALT:
                ins.mode = MODE_W'($urandom_range(3));
            default:
                ins.mode = (pick < 35) ? MODE_IMM : (pick < 70) ? MODE_DIRECT : MODE_INDIRECT;
        endcase
        pick = $urandom_range(99);
        if (ins.mode == MODE_IMM)
            ins.operand = (pick < 60) ? OPND_W'($urandom_range(15))
                                      : OPND_W'(int'($urandom_range(198)) - 99);
        else if (pick < 80)
            ins.operand = OPND_W'($urandom_range(15));
        else if (pick < 92)
            ins.operand = OPND_W'($urandom_range(99));
        else
            ins.operand = OPND_W'(int'($urandom_range(198)) - 99);
        return ins;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [MODE_W-1:0] mode,
                           input int opnd, input int tgt, input bit has,
                           input logic [WORD_W-1:0] tape, input bit fixed_exp,
                           input logic [WORD_W-1:0] exp_acc,
                           input logic [STATUS_W-1:0] exp_st);
        stim_row_t row;
        row.ins.op            = op;
        row.ins.mode          = mode;
        row.ins.operand       = OPND_W'(opnd);
        row.ins.jump_target   = TARGET_W'(tgt);
        row.ins.tape_has_item = has;
        row.ins.tape_value    = tape;
        row.fixed_exp         = fixed_exp;
        row.expd              = '0;
        row.expd.acc_value    = exp_acc;
        row.expd.status       = exp_st;
        stim_table.push_back(row);
    endtask

    task automatic build_table();
        // Rows with a typed result start from the reset state.
        add_row(OP_HALT,   MODE_DIRECT,   0,   0, 0, 0, 1, 32'h0, ST_HALTED);
        add_row(OP_BEYOND, MODE_BAD,      -1,  0, 1, 0, 1, 32'h0, ST_HALTED);
        add_row(OP_LOAD,   MODE_BAD,      3,   0, 0, 0, 1, 32'h0, ST_BAD_MODE);
        add_row(OP_READ,   MODE_BAD,      4,   0, 0, 0, 1, 32'h0, ST_BAD_MODE);
        add_row(OP_READ,   MODE_IMM,      4,   0, 0, 0, 1, 32'h0, ST_OK);
        add_row(OP_LOAD,   MODE_IMM,      99,  0, 0, 0, 1, 32'd99, ST_OK);
        add_row(OP_LOAD,   MODE_IMM,      -99, 0, 0, 0, 1, 32'hFFFF_FF9D, ST_OK);
        add_row(OP_STORE,  MODE_IMM,      5,   0, 0, 0, 1, 32'hFFFF_FF9D, ST_BAD_MODE);
        add_row(OP_STORE,  MODE_DIRECT,   -1,  0, 0, 0, 1, 32'hFFFF_FF9D, ST_BAD_INDEX);
        add_row(OP_STORE,  MODE_DIRECT,   5,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_LOAD,   MODE_INDIRECT, 5,   0, 0, 0, 1, 32'hFFFF_FF9D, ST_BAD_INDEX);
        add_row(OP_READ,   MODE_IMM,      10,  0, 1, 7, 1, 32'hFFFF_FF9D, ST_BAD_MODE);
        add_row(OP_READ,   MODE_DIRECT,   10,  0, 1, 32'h7FFF_FFFF, 0, 0, ST_OK);
        add_row(OP_READ,   MODE_DIRECT,   11,  0, 1, 32'h8000_0000, 0, 0, ST_OK);
        add_row(OP_READ,   MODE_DIRECT,   12,  0, 1, 32'd200, 0, 0, ST_OK);
        add_row(OP_LOAD,   MODE_INDIRECT, 12,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_LOAD,   MODE_DIRECT,   10,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_ADD,    MODE_IMM,      1,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_DIV,    MODE_IMM,      -1,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_DIV,    MODE_DIRECT,   0,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_MUL,    MODE_DIRECT,   11,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_READ,   MODE_DIRECT,   13,  0, 1, 32'd127, 0, 0, ST_OK);
        add_row(OP_SUB,    MODE_IMM,      -99, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_STORE,  MODE_INDIRECT, 13,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_WRITE,  MODE_IMM,      0,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_WRITE,  MODE_DIRECT,   -3,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_WRITE,  MODE_INDIRECT, 13,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_LOAD,   MODE_IMM,      -7,  0, 0, 0, 0, 0, ST_OK);
        add_row(OP_DIV,    MODE_IMM,      2,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_JUMP,   MODE_IMM,      0,   9, 0, 0, 0, 0, ST_OK);
        add_row(OP_JUMP,   MODE_DIRECT,   0, 1023, 0, 0, 0, 0, ST_OK);
        add_row(OP_JGTZ,   MODE_DIRECT,   0,   5, 0, 0, 0, 0, ST_OK);
        add_row(OP_LOAD,   MODE_IMM,      0,   0, 0, 0, 0, 0, ST_OK);
        add_row(OP_JZERO,  MODE_DIRECT,   0, 512, 0, 0, 0, 0, ST_OK);
    endtask

    // Offers one instruction and records what it must produce once the
    // transfer has happened.
    task automatic send_instr(input instr_t ins, input bit fixed_exp,
                              input exec_result_t expd);
        exec_result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_instr(ins);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = execute_instr(ins);
        pending_results.push_back(fixed_exp ? expd : pred);
        sent_count++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_instr(random_instr(), 1'b0, '0);
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] expv,
                               input logic [WORD_W-1:0] actv);
        if (actv !== expv)
        begin
            error_count++;
            $error("%s: expected %0h, got %0h", name, expv, actv);
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request that
    // this process counts out itself.
    initial
    begin : ready_driver
        int seen_id;
        int hold_left;
        seen_id = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_id != seen_id)
            begin
                seen_id = hold_id;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("result transfer with no instruction outstanding");
            end
            else
            begin
                want_res = pending_results.pop_front();
                got_res  = unpack_result(m_tdata);
                check_field("acc_value",     want_res.acc_value,     got_res.acc_value);
                check_field("out_valid",     WORD_W'(want_res.out_valid),
                            WORD_W'(got_res.out_valid));
                check_field("out_value",     want_res.out_value,     got_res.out_value);
                check_field("tape_taken",    WORD_W'(want_res.tape_taken),
                            WORD_W'(got_res.tape_taken));
                check_field("branch_taken",  WORD_W'(want_res.branch_taken),
                            WORD_W'(got_res.branch_taken));
                check_field("branch_target", WORD_W'(want_res.branch_target),
                            WORD_W'(got_res.branch_target));
                check_field("status",        WORD_W'(want_res.status),
                            WORD_W'(got_res.status));
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        acc_model = '0;
        foreach (reg_model[i])
            reg_model[i] = '0;
        build_table();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
            send_instr(stim_table[i].ins, stim_table[i].fixed_exp, stim_table[i].expd);
        s_tvalid <= 1'b0;
        wait_drained();

        run_phase(0,  0,  100);
        run_phase(86, 0,  80);
        run_phase(0,  86, 80);
        run_phase(23, 23, 80);

        // The output is held off for a long stretch while instructions keep
        // coming, so the block fills and stops taking transfers.
        hold_len = 300;
        hold_id++;
        run_phase(0, 0, 30);

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $error("%0d expected results never arrived", pending_results.size());
        end

        $display("Sent %0d instructions and checked %0d results: directed corner cases,",
                 sent_count, checked_count);
        $display("four idle and stall mixes, and a long output hold-off.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rmx_pkg.sv
hw/rtl/rmx_ram.sv
hw/rtl/ram_machine_execute_unit_top.sv
tb/ram_machine_execute_unit_top_tb.sv
